@@ design/icymd_pkg.sv @@
// shared types, codes and constants of the icy metadata stream demux
package icymd_pkg;

   localparam int INTERVAL_BITS_DEFAULT = 24;

   // stream phase codes
   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_AUDIO  = 2'd1;
   localparam logic [1:0] PH_LEN    = 2'd2;
   localparam logic [1:0] PH_META   = 2'd3;

   // title phase codes
   localparam logic [1:0] TI_WAIT  = 2'd0;
   localparam logic [1:0] TI_IN    = 2'd1;
   localparam logic [1:0] TI_QUOTE = 2'd2;
   localparam logic [1:0] TI_DONE  = 2'd3;

   // number reader modes
   localparam logic [1:0] NUM_OFF   = 2'd0;
   localparam logic [1:0] NUM_BLANK = 2'd1;
   localparam logic [1:0] NUM_DIGIT = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_AUDIO = 2'd0;
   localparam logic [1:0] KIND_TITLE = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [3:0] KEY_LEN  = 4'd12;
   // fallback point: "i" after "icy-metai"
   localparam logic [3:0] KEY_BORDER = 4'd9;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] out_kind;
      logic       last_of_run;
   } rsp_item_type;

   // characters of "icy-metaint:"
   function automatic logic [7:0] key_char(input logic [3:0] idx);
      logic [7:0] ch;
      unique case (idx)
         4'd0:    ch = 8'h69; // i
         4'd1:    ch = 8'h63; // c
         4'd2:    ch = 8'h79; // y
         4'd3:    ch = 8'h2D; // -
         4'd4:    ch = 8'h6D; // m
         4'd5:    ch = 8'h65; // e
         4'd6:    ch = 8'h74; // t
         4'd7:    ch = 8'h61; // a
         4'd8:    ch = 8'h69; // i
         4'd9:    ch = 8'h6E; // n
         4'd10:   ch = 8'h74; // t
         4'd11:   ch = 8'h3A; // :
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

@@ design/icymd_req_if.sv @@
// input byte channel of the icy metadata stream demux
interface icymd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       chunk_last;

   modport source (output valid, output in_byte, output chunk_last, input ready);
   modport sink (input valid, input in_byte, input chunk_last, output ready);
endinterface

@@ design/icymd_rsp_if.sv @@
// result channel of the icy metadata stream demux
interface icymd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] out_kind;
   logic       last_of_run;

   modport source (output valid, output out_byte, output out_kind, output last_of_run,
                   input ready);
   modport sink (input valid, input out_byte, input out_kind, input last_of_run,
                 output ready);
endinterface

@@ design/icy_metadata_stream_demux_unit.sv @@
// top level of the icy metadata stream demux
// Takes an HTTP radio response one byte per transaction. Header bytes produce
// nothing; an "icy-metaint:" key sets the metadata interval (decimal, saturating
// at 2^INTERVAL_BITS-1). After the blank line, audio bytes come out as kind 0,
// and with a nonzero interval each metadata block is parsed for the quoted
// title, which comes out as kind 1 characters and a kind 2 end marker. Each
// input byte is parsed in the cycle it is taken and yields zero to three
// results into a three-entry result buffer that drains one result per cycle
// while the receiver is ready. A byte with at most one result is taken every
// cycle then; with more, the input waits for its last result to be taken.
module icy_metadata_stream_demux_unit
   import icymd_pkg::*;
#(
   parameter int INTERVAL_BITS = INTERVAL_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   icymd_req_if.sink  req,
   icymd_rsp_if.source rsp
);

   localparam logic [INTERVAL_BITS-1:0] INTERVAL_MAX = '1;

   logic [1:0]               phase_ff, phase_in;
   logic [1:0]               blank_ff, blank_in;
   logic [3:0]               key_ff, key_in;
   logic [1:0]               num_ff, num_in;
   logic [INTERVAL_BITS-1:0] interval_ff, interval_in;
   logic [INTERVAL_BITS-1:0] count_ff, count_in;
   logic [11:0]              remain_ff, remain_in;
   logic [1:0]               title_ff, title_in;

   rsp_item_type res_ff [3];
   rsp_item_type res_in [3];
   logic [1:0]   cnt_ff, cnt_in;
   logic [1:0]   idx_ff, idx_in;
   logic [1:0]   n_new;

   logic req_fire, rsp_fire, one_left;

   assign rsp.valid       = (cnt_ff != idx_ff);
   assign rsp.out_byte    = res_ff[idx_ff].out_byte;
   assign rsp.out_kind    = res_ff[idx_ff].out_kind;
   assign rsp.last_of_run = res_ff[idx_ff].last_of_run;
   assign rsp_fire        = rsp.valid && rsp.ready;
   assign one_left        = ((idx_ff + 2'd1) == cnt_ff);
   assign req.ready       = !rsp.valid || (one_left && rsp.ready);
   assign req_fire        = req.valid && req.ready;

   // parse one byte: next state and its results
   always_comb begin
      logic [7:0]               b;
      logic [1:0]               t_v;
      logic [1:0]               n_v;
      logic                     done;
      logic                     last;
      logic [3:0]               digit;
      logic [INTERVAL_BITS+3:0] prod;
      logic [INTERVAL_BITS-1:0] cnt_inc;
      logic [3:0]               kp;

      b           = req.in_byte;
      phase_in    = phase_ff;
      blank_in    = blank_ff;
      key_in      = key_ff;
      num_in      = num_ff;
      interval_in = interval_ff;
      count_in    = count_ff;
      remain_in   = remain_ff;
      title_in    = title_ff;
      t_v         = title_ff;
      n_v         = 2'd0;
      done        = 1'b0;
      last        = 1'b0;
      digit       = b[3:0] - CH_ZERO[3:0];
      prod        = {1'b0, interval_ff, 3'b000} + {3'b000, interval_ff, 1'b0}
                    + {{INTERVAL_BITS{1'b0}}, digit};
      cnt_inc     = count_ff + {{(INTERVAL_BITS-1){1'b0}}, 1'b1};
      kp          = 4'd0;
      for (int i = 0; i < 3; i++) begin
         res_in[i] = '{out_byte: 8'h00, out_kind: KIND_AUDIO, last_of_run: 1'b0};
      end

      unique case (phase_ff)
         PH_HEADER: begin
            // blank line detector
            if (b == CH_CR) begin
               blank_in = (blank_ff == 2'd2) ? 2'd3 : 2'd1;
            end else if (b == CH_LF && blank_ff == 2'd1) begin
               blank_in = 2'd2;
            end else if (b == CH_LF && blank_ff == 2'd3) begin
               done = 1'b1;
            end else begin
               blank_in = 2'd0;
            end
            // decimal value reader
            if (num_ff == NUM_BLANK && (b == CH_SPACE || b == CH_TAB)) begin
               num_in = NUM_BLANK;
            end else if (num_ff != NUM_OFF && b >= CH_ZERO && b <= CH_NINE) begin
               interval_in = (prod[INTERVAL_BITS+3:INTERVAL_BITS] != 4'd0) ?
                             INTERVAL_MAX : prod[INTERVAL_BITS-1:0];
               num_in = NUM_DIGIT;
            end else begin
               num_in = NUM_OFF;
            end
            // key matcher
            if (key_ff < KEY_LEN && b == key_char(key_ff)) begin
               kp = key_ff + 4'd1;
            end else begin
               kp = (key_ff == KEY_BORDER) ? 4'd1 : 4'd0;
               kp = (b == key_char(kp)) ? kp + 4'd1 : 4'd0;
            end
            key_in = kp;
            if (kp == KEY_LEN) begin
               key_in      = 4'd0;
               num_in      = NUM_BLANK;
               interval_in = '0;
            end
            if (done) begin
               phase_in = PH_AUDIO;
               count_in = '0;
               blank_in = 2'd0;
               key_in   = 4'd0;
               num_in   = NUM_OFF;
            end
         end
         PH_AUDIO: begin
            res_in[n_v] = '{out_byte: b, out_kind: KIND_AUDIO, last_of_run: 1'b0};
            n_v = n_v + 2'd1;
            count_in = cnt_inc;
            if (interval_ff != '0 && cnt_inc >= interval_ff) begin
               count_in = '0;
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            remain_in = {b, 4'b0000};
            title_in  = TI_WAIT;
            phase_in  = (b != 8'h00) ? PH_META : PH_AUDIO;
         end
         PH_META: begin
            last      = (remain_ff <= 12'd1);
            remain_in = last ? 12'd0 : remain_ff - 12'd1;
            case (title_ff)
               TI_WAIT: begin
                  if (b == CH_QUOTE) t_v = TI_IN;
               end
               TI_IN: begin
                  if (b == CH_QUOTE) begin
                     t_v = TI_QUOTE;
                  end else begin
                     res_in[n_v] = '{out_byte: b, out_kind: KIND_TITLE, last_of_run: 1'b0};
                     n_v = n_v + 2'd1;
                  end
               end
               TI_QUOTE: begin
                  if (b == CH_SEMI) begin
                     res_in[n_v] = '{out_byte: 8'h00, out_kind: KIND_END,
                                     last_of_run: 1'b0};
                     n_v = n_v + 2'd1;
                     t_v = TI_DONE;
                  end else begin
                     // held quote was part of the title
                     res_in[n_v] = '{out_byte: CH_QUOTE, out_kind: KIND_TITLE,
                                     last_of_run: 1'b0};
                     n_v = n_v + 2'd1;
                     if (b != CH_QUOTE) begin
                        res_in[n_v] = '{out_byte: b, out_kind: KIND_TITLE,
                                        last_of_run: 1'b0};
                        n_v = n_v + 2'd1;
                        t_v = TI_IN;
                     end
                  end
               end
               default: ;
            endcase
            if (last) begin
               if (t_v == TI_QUOTE) begin
                  res_in[n_v] = '{out_byte: CH_QUOTE, out_kind: KIND_TITLE,
                                  last_of_run: 1'b0};
                  n_v = n_v + 2'd1;
               end
               if (t_v == TI_IN || t_v == TI_QUOTE) begin
                  res_in[n_v] = '{out_byte: 8'h00, out_kind: KIND_END, last_of_run: 1'b0};
                  n_v = n_v + 2'd1;
               end
               t_v      = TI_WAIT;
               phase_in = PH_AUDIO;
            end
            title_in = t_v;
         end
         default: ;
      endcase

      if (n_v != 2'd0) begin
         res_in[n_v - 2'd1].last_of_run = 1'b1;
      end
      n_new = n_v;
   end

   // result buffer bookkeeping
   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (req_fire) begin
         cnt_in = n_new;
         idx_in = 2'd0;
      end else if (rsp_fire) begin
         if (one_left) begin
            cnt_in = 2'd0;
            idx_in = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         blank_ff    <= 2'd0;
         key_ff      <= 4'd0;
         num_ff      <= NUM_OFF;
         interval_ff <= '0;
         count_ff    <= '0;
         remain_ff   <= 12'd0;
         title_ff    <= TI_WAIT;
         cnt_ff      <= 2'd0;
         idx_ff      <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
         if (req_fire) begin
            phase_ff    <= phase_in;
            blank_ff    <= blank_in;
            key_ff      <= key_in;
            num_ff      <= num_in;
            interval_ff <= interval_in;
            count_ff    <= count_in;
            remain_ff   <= remain_in;
            title_ff    <= title_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < 3; i++) begin
            res_ff[i] <= res_in[i];
         end
      end
   end

endmodule

@@ dv/icymd_tb_pkg.sv @@
// scoreboard that predicts and checks the outputs of the icy metadata stream demux
package icymd_tb_pkg;
   import icymd_pkg::*;

   class icy_demux_scoreboard;
      localparam int IV_BITS = INTERVAL_BITS_DEFAULT;

      logic [1:0]         stream_phase;
      logic [1:0]         crlf_seen;
      logic [3:0]         key_matched;
      logic [1:0]         number_mode;
      logic [IV_BITS-1:0] interval;
      logic [IV_BITS-1:0] audio_count;
      logic [11:0]        meta_left;
      logic [1:0]         title_phase;
      string              key_word;
      rsp_item_type       byte_outputs[$];
      rsp_item_type       pending_outputs[$];
      int                 mismatches;

      function new();
         key_word = "icy-metaint:";
         mismatches = 0;
         stream_phase = PH_HEADER;
         crlf_seen = 2'd0;
         key_matched = 4'd0;
         number_mode = NUM_OFF;
         interval = '0;
         audio_count = '0;
         meta_left = 12'd0;
         title_phase = TI_WAIT;
      endfunction

      function void add_output(logic [7:0] b, logic [1:0] kind);
         rsp_item_type item;
         item.out_byte = b;
         item.out_kind = kind;
         item.last_of_run = 1'b0;
         byte_outputs.push_back(item);
      endfunction

      function void header_byte(logic [7:0] b);
         logic            blank_line_done;
         longint unsigned next_value;
         longint unsigned iv_max;
         blank_line_done = 1'b0;
         iv_max = (64'd1 << IV_BITS) - 1;

         if (b == CH_CR)
            crlf_seen = (crlf_seen == 2'd2) ? 2'd3 : 2'd1;
         else if (b == CH_LF && crlf_seen == 2'd1)
            crlf_seen = 2'd2;
         else if (b == CH_LF && crlf_seen == 2'd3)
            blank_line_done = 1'b1;
         else
            crlf_seen = 2'd0;

         if (number_mode == NUM_BLANK && (b == CH_SPACE || b == CH_TAB)) begin
            // leading blanks before the digits
         end else if (number_mode != NUM_OFF && b >= CH_ZERO && b <= CH_NINE) begin
            next_value = longint'(interval) * 10 + longint'(b - CH_ZERO);
            interval = (next_value > iv_max) ? '1 : IV_BITS'(next_value);
            number_mode = NUM_DIGIT;
         end else begin
            number_mode = NUM_OFF;
         end

         if (key_matched < KEY_LEN && b == key_word[key_matched]) begin
            key_matched = key_matched + 4'd1;
         end else begin
            // only "i" after "icy-metai" can restart a partial match
            key_matched = (key_matched == KEY_BORDER) ? 4'd1 : 4'd0;
            if (b == key_word[key_matched])
               key_matched = key_matched + 4'd1;
            else
               key_matched = 4'd0;
         end
         if (key_matched == KEY_LEN) begin
            key_matched = 4'd0;
            number_mode = NUM_BLANK;
            interval = '0;
         end

         if (blank_line_done) begin
            stream_phase = PH_AUDIO;
            audio_count = '0;
            crlf_seen = 2'd0;
            key_matched = 4'd0;
            number_mode = NUM_OFF;
         end
      endfunction

      function void metadata_byte(logic [7:0] b);
         logic block_end;
         block_end = (meta_left <= 12'd1);
         meta_left = block_end ? 12'd0 : meta_left - 12'd1;
         case (title_phase)
            TI_WAIT: begin
               if (b == CH_QUOTE)
                  title_phase = TI_IN;
            end
            TI_IN: begin
               if (b == CH_QUOTE)
                  title_phase = TI_QUOTE;
               else
                  add_output(b, KIND_TITLE);
            end
            TI_QUOTE: begin
               if (b == CH_SEMI) begin
                  add_output(8'h00, KIND_END);
                  title_phase = TI_DONE;
               end else begin
                  // held quote was part of the title
                  add_output(CH_QUOTE, KIND_TITLE);
                  if (b != CH_QUOTE) begin
                     add_output(b, KIND_TITLE);
                     title_phase = TI_IN;
                  end
               end
            end
            default: ;
         endcase
         if (block_end) begin
            if (title_phase == TI_QUOTE)
               add_output(CH_QUOTE, KIND_TITLE);
            if (title_phase == TI_IN || title_phase == TI_QUOTE)
               add_output(8'h00, KIND_END);
            title_phase = TI_WAIT;
            stream_phase = PH_AUDIO;
         end
      endfunction

      // called once per accepted input transaction
      function void note_byte(logic [7:0] b);
         rsp_item_type item;
         byte_outputs.delete();
         case (stream_phase)
            PH_HEADER: header_byte(b);
            PH_AUDIO: begin
               add_output(b, KIND_AUDIO);
               audio_count = audio_count + 1'b1;
               if (interval != '0 && audio_count >= interval) begin
                  audio_count = '0;
                  stream_phase = PH_LEN;
               end
            end
            PH_LEN: begin
               meta_left = {b, 4'b0000};
               title_phase = TI_WAIT;
               stream_phase = (meta_left != 12'd0) ? PH_META : PH_AUDIO;
            end
            default: metadata_byte(b);
         endcase
         foreach (byte_outputs[i]) begin
            item = byte_outputs[i];
            item.last_of_run = (i == byte_outputs.size() - 1);
            pending_outputs.push_back(item);
         end
      endfunction

      // called once per accepted result transaction
      function void check_output(rsp_item_type got, longint unsigned now_ns);
         rsp_item_type want;
         if (pending_outputs.size() == 0) begin
            $display("%0d ns: unexpected output: expected none, got byte %02h kind %0d last %0b",
                     now_ns, got.out_byte, got.out_kind, got.last_of_run);
            mismatches++;
         end else begin
            want = pending_outputs.pop_front();
            if (got.out_byte !== want.out_byte) begin
               $display("%0d ns: out_byte mismatch: expected %02h, got %02h",
                        now_ns, want.out_byte, got.out_byte);
               mismatches++;
            end
            if (got.out_kind !== want.out_kind) begin
               $display("%0d ns: out_kind mismatch: expected %0d, got %0d",
                        now_ns, want.out_kind, got.out_kind);
               mismatches++;
            end
            if (got.last_of_run !== want.last_of_run) begin
               $display("%0d ns: last_of_run mismatch: expected %0b, got %0b",
                        now_ns, want.last_of_run, got.last_of_run);
               mismatches++;
            end
         end
      endfunction
   endclass

endpackage

@@ dv/tb_icy_metadata_stream_demux_unit.sv @@
// testbench top for the icy metadata stream demux
module tb_icy_metadata_stream_demux_unit;
   import icymd_pkg::*;
   import icymd_tb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET  = 460;
   localparam int CALM_ITEMS   = 60;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 2000000;

   logic clock = 1'b0;
   logic reset;

   icymd_req_if req_ch ();
   icymd_rsp_if rsp_ch ();

   icy_metadata_stream_demux_unit u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   icy_demux_scoreboard sb;
   rsp_item_type        seen_output;
   logic [7:0]          meta_q[$];
   int                  interval_used;
   int                  sent_bytes = 0;
   int                  stall_left = 0;
   int                  cycle_count = 0;
   bit                  idle_on = 1'b1;
   bit                  stall_on = 1'b1;

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // inputs noted before outputs so a same-edge result still finds its expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.note_byte(req_ch.in_byte);
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen_output.out_byte = rsp_ch.out_byte;
            seen_output.out_kind = rsp_ch.out_kind;
            seen_output.last_of_run = rsp_ch.last_of_run;
            sb.check_output(seen_output, $time);
         end
      end
   end

   // result side back-pressure in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 9) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.in_byte <= b;
      req_ch.chunk_last <= ($urandom_range(0, 15) == 0);
      sent_bytes++;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   task automatic send_line(input string s);
      send_text(s);
      send_byte(CH_CR);
      send_byte(CH_LF);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         meta_q.push_back(s[i]);
   endtask

   function automatic logic [7:0] title_char();
      case ($urandom_range(0, 9))
         0: return CH_QUOTE;
         1: return CH_SEMI;
         2: return 8'h00;
         3: return 8'($urandom_range(128, 255));
         default: return 8'($urandom_range(32, 126));
      endcase
   endfunction

   // one interval of audio, the length byte, then the block padded with zeros
   task automatic send_frame(input logic [7:0] len_code);
      int span;
      span = int'(len_code) * 16;
      repeat (interval_used) send_byte(8'($urandom_range(0, 255)));
      send_byte(len_code);
      for (int i = 0; i < span; i++)
         send_byte((i < meta_q.size()) ? meta_q[i] : 8'h00);
      meta_q.delete();
   endtask

   task automatic send_random_frame();
      logic [7:0] len_code;
      int         span;
      int         k;
      int         pick;
      pick = $urandom_range(0, 19);
      if (pick < 3)
         len_code = 8'd0;
      else if (pick < 16)
         len_code = 8'($urandom_range(1, 2));
      else
         len_code = 8'($urandom_range(3, 6));
      span = int'(len_code) * 16;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         add_text("StreamTitle='");
         repeat ($urandom_range(0, 24)) meta_q.push_back(title_char());
         add_text("';StreamUrl='';");
      end else if (pick < 9) begin
         repeat (span) meta_q.push_back(8'($urandom_range(0, 255)));
      end else if (span > 0) begin
         // opening quote close to the end of the block
         k = $urandom_range(1, 3);
         repeat (span - k) meta_q.push_back("x");
         meta_q.push_back(CH_QUOTE);
         repeat (k - 1) meta_q.push_back(title_char());
      end
      send_frame(len_code);
   endtask

   initial begin
      sb = new();
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.in_byte <= 8'h00;
      req_ch.chunk_last <= 1'b0;
      interval_used = $urandom_range(3, 14);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // header: case, overflow, sign, prefix, empty key, restart of a partial key
      send_line("HTTP/1.0 200 OK");
      send_text("icy-br:128");
      send_byte(CH_CR);
      send_line("");
      send_line("ICY-METAINT:5");
      send_line("icy-metaint:99999999999");
      repeat (12) begin
         logic [7:0] noise;
         do noise = 8'($urandom_range(0, 255)); while (noise == CH_CR || noise == CH_LF);
         send_byte(noise);
      end
      send_line("");
      send_line("icy-metaint:-4");
      send_line("icy-metaint:0x1F");
      send_line("icy-metaint:");
      send_line($sformatf("icy-metaicy-metaint: \t 00%0d;x", interval_used));
      send_line("");

      // zero length byte
      send_frame(8'd0);
      add_text("StreamTitle='Hi';StreamUrl='';");
      send_frame(8'd2);
      // block ends with a quote held back
      add_text("StreamTitle='Hi'");
      send_frame(8'd1);
      add_text("no title in here");
      send_frame(8'd1);
      // quote without semicolon and a doubled quote
      add_text("'a'b''c';");
      send_frame(8'd1);
      // opening quote as the last byte of the block
      repeat (15) meta_q.push_back("x");
      meta_q.push_back(CH_QUOTE);
      send_frame(8'd1);
      // zero bytes inside a title that runs to the block end
      meta_q.push_back(CH_QUOTE);
      send_frame(8'd1);
      add_text("StreamTitle='");
      repeat (25) meta_q.push_back(title_char());
      add_text("';");
      send_frame(8'd3);

      while (sent_bytes < ITEM_TARGET - CALM_ITEMS)
         send_random_frame();
      idle_on = 1'b0;
      stall_on = 1'b0;
      while (sent_bytes < ITEM_TARGET)
         send_random_frame();
      req_ch.valid <= 1'b0;

      while (sb.pending_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
